/* rtl/camera_attitude_update_defines.svh */
// assertion macros for the camera attitude update block
// used by camera_attitude_update.sv, expects clk and rst in scope
`ifndef CAMERA_ATTITUDE_UPDATE_DEFINES_SVH
`define CAMERA_ATTITUDE_UPDATE_DEFINES_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cau_pkg.sv */
// shared types and constants for the camera attitude update block
// no dependencies
`default_nettype none

package cau_pkg;

  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_FRAC   = 16;
  localparam int SPD_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ACC,
    S_FIN,
    S_SQRT,
    S_DRD,
    S_DST,
    S_DIV,
    S_NWR,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MOP_NSQ,
    MOP_DOT,
    MOP_K,
    MOP_RCR,
    MOP_ROT,
    MOP_CROSS,
    MOP_EYE
  } mop_t;

  typedef enum logic {
    RD_SQRT,
    RD_DIV
  } rd_op_t;

  typedef struct packed {
    logic   start;
    rd_op_t op;
  } rd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

endpackage

`default_nettype wire

/* rtl/cau_rootdiv.sv */
// shared bit-serial square root and divide unit
// depends on cau_pkg
`default_nettype none

module cau_rootdiv import cau_pkg::*; #(
  parameter int NW = 38,
  parameter int RW = 19
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rd_ctl_t         ctl,
  output rd_stat_t             stat,
  input  wire logic [NW-1:0]   n,
  input  wire logic [RW-1:0]   den,
  output logic      [NW-1:0]   res
);

  localparam int CW         = RW + 3;
  localparam int CNTW       = $clog2(NW + 1);
  localparam int SQRT_STEPS = NW / 2;

  rd_op_t          mode;
  logic            busy;
  logic            done;
  logic [CNTW-1:0] cnt;
  logic [RW:0]     rem;
  logic [NW-1:0]   nsh;
  logic [CW-1:0]   cand;
  logic [CW-1:0]   trial;
  logic [CW-1:0]   diff;
  logic            ge;

  // one compare-subtract shared by both recurrences
  always_comb begin
    if (mode == RD_SQRT) begin
      cand  = {rem, nsh[NW-1:NW-2]};
      trial = {1'b0, res[RW-1:0], 2'b01};
    end else begin
      cand  = {2'b00, rem[RW-1:0], nsh[NW-1]};
      trial = {3'b000, den};
    end
    ge   = (cand >= trial);
    diff = cand - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      mode <= RD_SQRT;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        mode <= ctl.op;
        nsh  <= n;
        rem  <= '0;
        res  <= '0;
        cnt  <= (ctl.op == RD_SQRT) ? CNTW'(SQRT_STEPS) : CNTW'(NW);
      end else if (busy) begin
        rem <= ge ? diff[RW:0] : cand[RW:0];
        res <= {res[NW-2:0], ge};
        nsh <= (mode == RD_SQRT) ? {nsh[NW-3:0], 2'b00} : {nsh[NW-2:0], 1'b0};
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

/* rtl/camera_attitude_update.sv */
// camera attitude update: one frame tick in, updated camera frame out
// a tick with no rotation only moves the eye; pitch and roll each check two vectors
// and renormalize those off unit length, each renormalization a root of NW/2 steps
// and three divides of NW steps on the shared root/divide unit; each product term
// passes through the read, multiply and accumulate states of the shared multiplier.
// one tick at a time: s_tready is high only while idle, so no new tick is taken until
// the last frame has been accepted. synchronous reset restores the initial frame and default step
`default_nettype none
`include "camera_attitude_update_defines.svh"

module camera_attitude_update import cau_pkg::*; #(
  parameter int DIR_FRAC_BITS = 16,
  parameter int POS_WIDTH     = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input tick: pitch_dir [1:0], roll_dir [3:2], speed [19:4], zero [23:20]
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [23:0]          s_tdata,
  // frame: eye_x [31:0], eye_y [63:32], eye_z [95:64], fwd_x [114:96],
  // fwd_y [133:115], fwd_z [152:134], up_x [171:153], up_y [190:172],
  // up_z [209:191], side_x [228:210], side_y [247:229], side_z [266:248],
  // zero [271:267]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [271:0]              m_tdata,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int F   = DIR_FRAC_BITS;
  localparam int DW  = F + 3;
  localparam int MW  = (DW > SPD_W) ? DW : SPD_W;
  localparam int PW  = 2 * MW;
  localparam int AW  = PW + 2;
  localparam int NW  = 2 * F + 6;
  localparam int RW  = F + 3;
  localparam int EW  = ((POS_WIDTH > PW) ? POS_WIDTH : PW) + 2;
  localparam int SHL = (F >= CFG_FRAC) ? F - CFG_FRAC : 0;
  localparam int SHR = (F < CFG_FRAC) ? CFG_FRAC - F : 0;

  localparam longint ONE_L   = longint'(1) << F;
  localparam longint P4_L    = (2 * ONE_L + 2) / 5;
  localparam longint P1_L    = (ONE_L + 5) / 10;
  localparam longint ONE2_L  = longint'(1) << (2 * F);
  localparam longint TOL_L   = (ONE2_L * 2) / 1000000;
  localparam longint CHALF_L = (SHR > 0) ? (longint'(1) << (SHR - 1)) : 0;
  localparam longint DHI_L   = (longint'(1) << (DW - 1)) - 1;
  localparam longint EHI_L   = (longint'(1) << (POS_WIDTH - 1)) - 1;

  localparam logic signed [AW-1:0] DHI   = AW'(DHI_L);
  localparam logic signed [AW-1:0] DLO   = -DHI - AW'(1);
  localparam logic signed [EW-1:0] EHI   = EW'(EHI_L);
  localparam logic signed [EW-1:0] ELO   = -EHI - EW'(1);
  localparam logic signed [AW-1:0] TLO   = AW'(ONE2_L - TOL_L);
  localparam logic signed [AW-1:0] THI   = AW'(ONE2_L + TOL_L);
  localparam logic signed [AW-1:0] RHF   = AW'(longint'(1) << (F - 1));
  localparam logic signed [AW-1:0] RHS   = AW'(longint'(1) << (SPD_W - 1));
  localparam logic signed [MW-1:0] ONE_M = MW'(ONE_L);

  function automatic logic signed [DW-1:0] dsat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    t = v;
    if (v > DHI) t = DHI;
    if (v < DLO) t = DLO;
    return t[DW-1:0];
  endfunction

  function automatic logic signed [MW-1:0] cfg_scale(input logic [CFG_W-1:0] raw);
    logic [63:0] w;
    if (F >= CFG_FRAC) w = {47'b0, raw} << SHL;
    else               w = ({47'b0, raw} + 64'(CHALF_L)) >> SHR;
    return $signed(w[MW-1:0]);
  endfunction

  function automatic logic [18:0] dir_out(input logic signed [DW-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[18:0];
  endfunction

  function automatic logic [31:0] eye_out(input logic signed [POS_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  // control
  state_t state, state_next;
  mop_t   mop, mop_next;
  logic   half, half_next;
  logic   nsel, nsel_next;
  logic [1:0] i, i_next;
  logic [1:0] j, j_next;

  // camera frame; slot 0 forward, 1 up, 2 right, 3 rotation cross term
  logic signed [DW-1:0]        vec [4][3];
  logic signed [POS_WIDTH-1:0] eye [3];
  logic [CFG_W-1:0]            cos_r;
  logic [CFG_W-1:0]            sin_r;

  // tick fields
  logic [1:0]              pd;
  logic [1:0]              rd;
  logic signed [SPD_W-1:0] spd;

  // datapath
  logic signed [DW-1:0] dreg;
  logic signed [DW-1:0] kreg;
  logic signed [MW-1:0] opa, opb;
  logic                 sub;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic [RW-1:0]        len;

  logic signed [MW-1:0] a_c, b_c, c_s, s_s, s_sig, omc;
  logic                 sub_c;
  logic [1:0]           vs, rs, ds, ns, i1, i2, j_last;
  logic signed [AW-1:0] acc_base, acc_sum, rnd_f, rnd_s, q_s;
  logic signed [DW-1:0] res_d;
  logic signed [EW-1:0] eye_sum, eye_sat;
  logic                 in_tol;
  logic [MW-1:0]        mag;
  logic [NW-1:0]        div_n, rd_n;
  logic [NW-1:0]        rd_res;
  rd_ctl_t              rd_ctl;
  rd_stat_t             rd_stat;

  // slots used by the current half: pitch turns forward about right,
  // roll turns up about forward
  assign vs = half ? 2'd1 : 2'd0;
  assign rs = half ? 2'd0 : 2'd2;
  assign ds = half ? 2'd2 : 2'd1;
  assign ns = 2'(half) + 2'(nsel);
  assign i1 = (i == 2'd2) ? 2'd0 : i + 2'd1;
  assign i2 = (i == 2'd0) ? 2'd2 : i - 2'd1;

  assign c_s   = cfg_scale(cos_r);
  assign s_s   = cfg_scale(sin_r);
  assign omc   = ONE_M - c_s;
  assign s_sig = (half ? rd[1] : pd[1]) ? -s_s : s_s;

  // operand fetch for the shared multiplier
  always_comb begin
    a_c   = '0;
    b_c   = '0;
    sub_c = 1'b0;
    case (mop)
      MOP_NSQ: begin
        a_c = MW'(vec[ns][j]);
        b_c = MW'(vec[ns][j]);
      end
      MOP_DOT: begin
        a_c = MW'(vec[rs][j]);
        b_c = MW'(vec[vs][j]);
      end
      MOP_K: begin
        a_c = omc;
        b_c = MW'(dreg);
      end
      MOP_RCR, MOP_CROSS: begin
        // r x v, second term subtracted
        if (j == 2'd0) begin
          a_c = MW'(vec[rs][i1]);
          b_c = MW'(vec[vs][i2]);
        end else begin
          a_c   = MW'(vec[rs][i2]);
          b_c   = MW'(vec[vs][i1]);
          sub_c = 1'b1;
        end
      end
      MOP_ROT: begin
        case (j)
          2'd0:    begin a_c = MW'(vec[rs][i]); b_c = MW'(kreg); end
          2'd1:    begin a_c = MW'(vec[vs][i]); b_c = c_s; end
          default: begin a_c = MW'(vec[3][i]);  b_c = s_sig; end
        endcase
      end
      MOP_EYE: begin
        a_c = MW'(vec[0][i]);
        b_c = MW'(spd);
      end
      default: ;
    endcase
  end

  always_comb begin
    case (mop)
      MOP_NSQ, MOP_DOT, MOP_ROT: j_last = 2'd2;
      MOP_RCR, MOP_CROSS:        j_last = 2'd1;
      default:                   j_last = 2'd0;
    endcase
  end

  assign acc_base = (j == 2'd0) ? '0 : acc;
  assign acc_sum  = sub ? acc_base - AW'(prod) : acc_base + AW'(prod);
  assign rnd_f    = (acc + RHF) >>> F;
  assign rnd_s    = (acc + RHS) >>> SPD_W;
  assign res_d    = dsat(rnd_f);
  assign in_tol   = (acc >= TLO) && (acc <= THI);
  assign eye_sum  = EW'(eye[i]) + EW'(rnd_s);
  assign eye_sat  = (eye_sum > EHI) ? EHI : ((eye_sum < ELO) ? ELO : eye_sum);

  // divide operand: |v| scaled, plus half the length for rounding
  assign mag   = opa[MW-1] ? MW'(-opa) : MW'(opa);
  assign div_n = (NW'(mag) << F) + NW'(len >> 1);
  assign rd_n  = (state == S_FIN) ? acc[NW-1:0] : div_n;
  assign q_s   = $signed(AW'(rd_res));

  cau_rootdiv #(
    .NW(NW),
    .RW(RW)
  ) u_rootdiv (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .stat (rd_stat),
    .n    (rd_n),
    .den  (len),
    .res  (rd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mop   <= MOP_EYE;
      half  <= 1'b0;
      nsel  <= 1'b0;
      i     <= 2'd0;
      j     <= 2'd0;
    end else begin
      state <= state_next;
      mop   <= mop_next;
      half  <= half_next;
      nsel  <= nsel_next;
      i     <= i_next;
      j     <= j_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    mop_next   = mop;
    half_next  = half;
    nsel_next  = nsel;
    i_next     = i;
    j_next     = j;
    rd_ctl     = '{start: 1'b0, op: RD_SQRT};
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          i_next    = 2'd0;
          j_next    = 2'd0;
          nsel_next = 1'b0;
          if (s_tdata[1:0] != 2'd0) begin
            half_next = 1'b0;
            mop_next  = MOP_NSQ;
          end else if (s_tdata[3:2] != 2'd0) begin
            half_next = 1'b1;
            mop_next  = MOP_NSQ;
          end else begin
            mop_next = MOP_EYE;
          end
          state_next = S_RD;
        end
      end
      S_RD:  state_next = S_MUL;
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        if (j == j_last) begin
          state_next = S_FIN;
        end else begin
          j_next     = j + 2'd1;
          state_next = S_RD;
        end
      end
      S_FIN: begin
        j_next     = 2'd0;
        state_next = S_RD;
        case (mop)
          MOP_NSQ: begin
            if (in_tol) begin
              i_next = 2'd0;
              if (!nsel) nsel_next = 1'b1;
              else       mop_next  = MOP_DOT;
            end else begin
              rd_ctl     = '{start: 1'b1, op: RD_SQRT};
              state_next = S_SQRT;
            end
          end
          MOP_DOT: mop_next = MOP_K;
          MOP_K: begin
            mop_next = MOP_RCR;
            i_next   = 2'd0;
          end
          MOP_RCR: begin
            if (i == 2'd2) begin
              mop_next = MOP_ROT;
              i_next   = 2'd0;
            end else begin
              i_next = i + 2'd1;
            end
          end
          MOP_ROT: begin
            if (i == 2'd2) begin
              mop_next = MOP_CROSS;
              i_next   = 2'd0;
            end else begin
              i_next = i + 2'd1;
            end
          end
          MOP_CROSS: begin
            if (i == 2'd2) begin
              i_next = 2'd0;
              // end of pitch half: go to roll if asked
              if (!half && rd != 2'd0) begin
                half_next = 1'b1;
                nsel_next = 1'b0;
                mop_next  = MOP_NSQ;
              end else begin
                mop_next = MOP_EYE;
              end
            end else begin
              i_next = i + 2'd1;
            end
          end
          MOP_EYE: begin
            if (i == 2'd2) state_next = S_OUT;
            else           i_next     = i + 2'd1;
          end
          default: ;
        endcase
      end
      S_SQRT: begin
        if (rd_stat.done) begin
          i_next = 2'd0;
          if (rd_res[RW-1:0] == '0) begin
            // zero length: vector kept as it is
            j_next     = 2'd0;
            state_next = S_RD;
            if (!nsel) nsel_next = 1'b1;
            else       mop_next  = MOP_DOT;
          end else begin
            state_next = S_DRD;
          end
        end
      end
      S_DRD: state_next = S_DST;
      S_DST: begin
        rd_ctl     = '{start: 1'b1, op: RD_DIV};
        state_next = S_DIV;
      end
      S_DIV: begin
        if (rd_stat.done) state_next = S_NWR;
      end
      S_NWR: begin
        if (i == 2'd2) begin
          i_next     = 2'd0;
          j_next     = 2'd0;
          state_next = S_RD;
          if (!nsel) nsel_next = 1'b1;
          else       mop_next  = MOP_DOT;
        end else begin
          i_next     = i + 2'd1;
          state_next = S_DRD;
        end
      end
      S_OUT: begin
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_r     <= CFG_W'(65454);
      sin_r     <= CFG_W'(3275);
      eye[0]    <= '0;
      eye[1]    <= '0;
      eye[2]    <= POS_WIDTH'(P4_L);
      vec[0][0] <= DW'(P4_L);
      vec[0][1] <= DW'(P1_L);
      vec[0][2] <= -DW'(ONE_L);
      vec[1][0] <= '0;
      vec[1][1] <= DW'(ONE_L);
      vec[1][2] <= '0;
      vec[2][0] <= DW'(ONE_L);
      vec[2][1] <= '0;
      vec[2][2] <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_COS) cos_r <= cfg_data;
        if (cfg_index == REG_SIN) sin_r <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pd  <= s_tdata[1:0];
            rd  <= s_tdata[3:2];
            spd <= $signed(s_tdata[19:4]);
          end
        end
        S_RD: begin
          opa <= a_c;
          opb <= b_c;
          sub <= sub_c;
        end
        S_MUL: prod <= opa * opb;
        S_ACC: acc <= acc_sum;
        S_FIN: begin
          case (mop)
            MOP_DOT:   dreg         <= res_d;
            MOP_K:     kreg         <= res_d;
            MOP_RCR:   vec[3][i]    <= res_d;
            MOP_ROT:   vec[vs][i]   <= res_d;
            MOP_CROSS: vec[ds][i]   <= res_d;
            MOP_EYE:   eye[i]       <= eye_sat[POS_WIDTH-1:0];
            default: ;
          endcase
        end
        S_SQRT: begin
          if (rd_stat.done) len <= rd_res[RW-1:0];
        end
        S_DRD: opa <= MW'(vec[ns][i]);
        S_NWR: vec[ns][i] <= dsat(opa[MW-1] ? -q_s : q_s);
        default: ;
      endcase
    end
  end

  // handshake and result packing
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign cfg_ready = 1'b1;

  always_comb begin
    m_tdata           = '0;
    m_tdata[31:0]     = eye_out(eye[0]);
    m_tdata[63:32]    = eye_out(eye[1]);
    m_tdata[95:64]    = eye_out(eye[2]);
    m_tdata[114:96]   = dir_out(vec[0][0]);
    m_tdata[133:115]  = dir_out(vec[0][1]);
    m_tdata[152:134]  = dir_out(vec[0][2]);
    m_tdata[171:153]  = dir_out(vec[1][0]);
    m_tdata[190:172]  = dir_out(vec[1][1]);
    m_tdata[209:191]  = dir_out(vec[1][2]);
    m_tdata[228:210]  = dir_out(vec[2][0]);
    m_tdata[247:229]  = dir_out(vec[2][1]);
    m_tdata[266:248]  = dir_out(vec[2][2]);
  end

  // checks
  `CAU_ASSERT_IMP(a_no_overlap, s_tready, !m_tvalid, "input and output open together")
  `CAU_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
                  "ready stayed high after a transaction")
  `CAU_ASSERT_IMP(a_start_idle_unit, rd_ctl.start, !rd_stat.busy,
                  "root/divide started while busy")
  `CAU_ASSERT_IMP(a_done_waited, rd_stat.done, state == S_SQRT || state == S_DIV,
                  "root/divide finished with nobody waiting")

endmodule

`default_nettype wire

/* test/tb_camera_attitude_update.sv */
// self-checking bench for camera_attitude_update: directed and random frame
// ticks against a bit-true camera frame predictor; depends on cau_pkg and the block's rtl
`default_nettype none

module tb_camera_attitude_update import cau_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int DIRW = 19;
  localparam int EYEW = 32;

  typedef longint vec_t [3];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [271:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COS;
  logic [CFG_W-1:0] cfg_data = '0;

  camera_attitude_update u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted camera frame and step registers
  vec_t eye_pos, fwd_dir, up_dir, side_dir;
  longint cos_reg, sin_reg;

  logic [23:0] tick_q[$];   // ticks waiting to be driven
  logic [271:0] frame_q[$]; // predicted frames waiting for the block
  int ticks_owed = 0;       // queued or presented, not yet accepted
  int errors = 0;
  bit no_gaps = 1'b0;       // stretch with both sides always ready

  string field_name [12] = '{"eye_x", "eye_y", "eye_z", "fwd_x", "fwd_y", "fwd_z",
                             "up_x", "up_y", "up_z", "side_x", "side_y", "side_z"};

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // add half an lsb, then floor shift
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic vec_t cross_prod(vec_t a, vec_t b);
    vec_t o;
    o[0] = clip(round_shift(a[1] * b[2] - a[2] * b[1], FRAC), DIRW);
    o[1] = clip(round_shift(a[2] * b[0] - a[0] * b[2], FRAC), DIRW);
    o[2] = clip(round_shift(a[0] * b[1] - a[1] * b[0], FRAC), DIRW);
    return o;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // renormalize, left alone near unit length or at zero length
  function automatic vec_t unitize(vec_t v);
    longint unsigned sq, one2, tol, len, mag, q;
    vec_t o;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += longint'(v[i] * v[i]);
    one2 = 64'd1 << (2 * FRAC);
    tol = (one2 * 2) / 1000000;
    if (sq >= one2 - tol && sq <= one2 + tol) return v;
    len = int_root(sq);
    if (len == 0) return v;
    for (int i = 0; i < 3; i++) begin
      mag = longint'(v[i] < 0 ? -v[i] : v[i]) << FRAC;
      q = (mag + len / 2) / len;
      o[i] = clip(v[i] < 0 ? -longint'(q) : longint'(q), DIRW);
    end
    return o;
  endfunction

  // rodrigues rotation of v about axis r
  function automatic vec_t spin(vec_t v, vec_t r, longint c, longint s);
    longint d, k;
    vec_t cr, o;
    d = clip(round_shift(v[0] * r[0] + v[1] * r[1] + v[2] * r[2], FRAC), DIRW);
    k = clip(round_shift(((longint'(1) << FRAC) - c) * d, FRAC), DIRW);
    cr = cross_prod(r, v);
    for (int i = 0; i < 3; i++)
      o[i] = clip(round_shift(r[i] * k + v[i] * c + cr[i] * s, FRAC), DIRW);
    return o;
  endfunction

  // advance the predicted camera and return the frame it should output
  function automatic logic [271:0] advance_camera(logic [23:0] d);
    logic [1:0] pitch, roll;
    longint spd, val;
    logic [271:0] f;
    int lo, w;
    pitch = d[1:0];
    roll = d[3:2];
    spd = longint'(signed'(d[19:4]));
    if (pitch != 0) begin
      fwd_dir = unitize(fwd_dir);
      up_dir = unitize(up_dir);
      fwd_dir = spin(fwd_dir, side_dir, cos_reg, pitch[1] ? -sin_reg : sin_reg);
      up_dir = cross_prod(side_dir, fwd_dir);
    end
    if (roll != 0) begin
      up_dir = unitize(up_dir);
      side_dir = unitize(side_dir);
      up_dir = spin(up_dir, fwd_dir, cos_reg, roll[1] ? -sin_reg : sin_reg);
      side_dir = cross_prod(fwd_dir, up_dir);
    end
    for (int i = 0; i < 3; i++)
      eye_pos[i] = clip(eye_pos[i] + round_shift(fwd_dir[i] * spd, FRAC), EYEW);
    f = '0;
    for (int i = 0; i < 12; i++) begin
      lo = i < 3 ? 32 * i : 96 + DIRW * (i - 3);
      w = i < 3 ? 32 : DIRW;
      case (i / 3)
        0: val = eye_pos[i % 3];
        1: val = fwd_dir[i % 3];
        2: val = up_dir[i % 3];
        default: val = side_dir[i % 3];
      endcase
      f |= (272'(val) & ((272'(1) << w) - 1)) << lo;
    end
    return f;
  endfunction

  // clock; the one reset is released in the main sequence
  initial begin
    forever #5 clk = ~clk;
  end

  // tick driver: presents queued ticks, predicts each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        frame_q.push_back(advance_camera(s_tdata));
        ticks_owed--;
      end
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() > 0 && (no_gaps || $urandom_range(99) >= 30)) begin
          s_tvalid <= 1'b1;
          s_tdata <= tick_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // frame monitor: random back-pressure, field by field compare
  always @(posedge clk) begin
    logic [271:0] want;
    int lo, w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (frame_q.size() == 0) begin
          $error("frame transaction with no tick outstanding");
          errors++;
        end else begin
          want = frame_q.pop_front();
          for (int i = 0; i < 12; i++) begin
            lo = i < 3 ? 32 * i : 96 + DIRW * (i - 3);
            w = i < 3 ? 32 : DIRW;
            if (((want ^ m_tdata) >> lo) & ((272'(1) << w) - 1)) begin
              $error("%s expected %h actual %h", field_name[i],
                     (want >> lo) & ((272'(1) << w) - 1),
                     (m_tdata >> lo) & ((272'(1) << w) - 1));
              errors++;
            end
          end
        end
      end
      m_tready <= no_gaps || $urandom_range(99) >= 30;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_COS) cos_reg = val;
    else sin_reg = val;
  endtask

  task automatic queue_tick(int pitch, int roll, int spd);
    logic [23:0] d;
    d = '0;
    d[1:0] = pitch[1:0];
    d[3:2] = roll[1:0];
    d[19:4] = spd[15:0];
    tick_q.push_back(d);
    ticks_owed++;
  endtask

  // random ticks, then wait for every frame and let the block settle
  task automatic run_ticks(int n);
    int spd;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: spd = 32767;
        1: spd = -32768;
        default: spd = $urandom;
      endcase
      queue_tick($urandom_range(3), $urandom_range(3), spd);
    end
    while (ticks_owed != 0 || frame_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int speeds [5];
    speeds = '{32767, -32768, 0, 1, -1};
    eye_pos = '{0, 0, 26214};
    fwd_dir = '{26214, 6554, -65536};
    up_dir = '{0, 65536, 0};
    side_dir = '{65536, 0, 0};
    cos_reg = 65454;
    sin_reg = 3275;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: every pitch and roll code, incl. the negative codes 2 and 3
    for (int p = 0; p < 4; p++)
      for (int r = 0; r < 4; r++)
        queue_tick(p, r, speeds[(p * 4 + r) % 5]);
    queue_tick(0, 0, 32767);
    queue_tick(0, 0, -32768);
    run_ticks(480);

    // identity rotation
    write_reg(REG_COS, 17'd65536);
    write_reg(REG_SIN, 17'd0);
    run_ticks(200);

    // quarter turn per step, no idling on either side
    no_gaps = 1'b1;
    write_reg(REG_COS, 17'd0);
    write_reg(REG_SIN, 17'd65536);
    run_ticks(200);
    no_gaps = 1'b0;

    // zero step collapses vectors, exercises zero-length renormalize
    write_reg(REG_SIN, 17'd0);
    run_ticks(100);

    // out-of-range register values used as given
    write_reg(REG_COS, 17'h1FFFF);
    write_reg(REG_SIN, 17'h1FFFF);
    run_ticks(200);

    write_reg(REG_COS, 17'($urandom_range(65536)));
    write_reg(REG_SIN, 17'($urandom_range(65536)));
    run_ticks(300);

    write_reg(REG_COS, 17'd65454);
    write_reg(REG_SIN, 17'd3275);
    run_ticks(300);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
